/* sv/caft_pkg.sv */
// ----------------------------------------------------------------------------
// caft_pkg: shared types and constants
// beat payloads, configuration image, history and flag bundles for the
// continuous autofocus trigger
// ----------------------------------------------------------------------------
package caft_pkg;

    // force request codes, code 3 is unused and behaves as none
    localparam logic [1:0] FORCE_NONE  = 2'd0;
    localparam logic [1:0] FORCE_START = 2'd1;
    localparam logic [1:0] FORCE_STOP  = 2'd2;
    localparam logic [1:0] FORCE_RSVD  = 2'd3;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_STARTUP_DELAY  = 3'd0,
        CFG_VALID_HOLD     = 3'd1,
        CFG_SINGLE_HOLD    = 3'd2,
        CFG_TRIGGER_DELAY  = 3'd3,
        CFG_SHAKE_HOLD     = 3'd4,
        CFG_CAPTURE_WINDOW = 3'd5
    } t_cfg_idx;

    // sharpness is usable with 4 to 7 decimal digits
    localparam logic [23:0] C_SHARP_MIN = 24'd1000;
    localparam logic [23:0] C_SHARP_MAX = 24'd9999999;
    // five and six digit ranges pick the relative threshold
    localparam logic [23:0] C_DIG5_MIN  = 24'd10000;
    localparam logic [23:0] C_DIG5_MAX  = 24'd99999;
    localparam logic [23:0] C_DIG6_MIN  = 24'd100000;
    localparam logic [23:0] C_DIG6_MAX  = 24'd999999;
    localparam logic [5:0]  C_THR_DIV5  = 6'd50;
    localparam logic [8:0]  C_THR_DIV6  = 9'd300;

    // percent style checks on brightness and white balance
    localparam logic [6:0]  C_PCT_SCALE   = 7'd100;
    localparam logic [3:0]  C_BR_PCT      = 4'd10;
    localparam logic [4:0]  C_WB_PCT_LAST = 5'd30;
    localparam logic [2:0]  C_WB_PCT_REF  = 3'd5;
    localparam logic [15:0] C_QUIET_LIM   = 16'd5;
    localparam logic [15:0] C_WB_MIN_STEP = 16'd50;

    typedef struct packed {
        logic [23:0] sharpness;
        logic [15:0] white_balance;
        logic [15:0] brightness;
        logic [1:0]  force_request;
        logic        lens_settled;
        logic        single_focus_active;
        logic        capture_started;
        logic        motion_started;
    } t_in_item;

    typedef struct packed {
        logic focus_trigger;
        logic tracking_valid;
    } t_out_item;

    typedef struct packed {
        logic [7:0] startup_delay;
        logic [7:0] valid_hold;
        logic [7:0] single_hold;
        logic [7:0] trigger_delay;
        logic [7:0] shake_hold;
        logic [7:0] capture_window;
    } t_cfg;

    localparam t_cfg C_CFG_RESET = '{
        startup_delay:  8'd10,
        valid_hold:     8'd5,
        single_hold:    8'd5,
        trigger_delay:  8'd3,
        shake_hold:     8'd5,
        capture_window: 8'd10
    };

    // statistics remembered from earlier frames
    typedef struct packed {
        logic [23:0] last_sharpness;
        logic [15:0] last_balance;
        logic [15:0] last_brightness;
        logic [15:0] ref_balance;
        logic [15:0] ref_brightness;
    } t_hist;

    // comparator results handed to the control logic
    typedef struct packed {
        logic sharp_ok;
        logic change_hit;
        logic scene_hit;
    } t_flags;

endpackage

/* sv/caft_if.sv */
// ----------------------------------------------------------------------------
// caft_if: valid/ready channel
// one beat moves when valid and ready are both high at a rising clock edge
// ----------------------------------------------------------------------------
interface caft_if #(
    parameter type T = caft_pkg::t_in_item
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/caft_stats.sv */
// ----------------------------------------------------------------------------
// caft_stats: frame statistic comparators
// sharpness range, change detector and scene check against stored statistics
// ----------------------------------------------------------------------------
module caft_stats (
    input  caft_pkg::t_in_item i_item,
    input  caft_pkg::t_hist    i_hist,
    output caft_pkg::t_flags   o_flags
);
    logic [23:0] w_sd;
    logic [15:0] w_wd, w_bd, w_wd_ref, w_bd_ref;
    logic        w_start, w_stop;
    logic        w_dig5, w_dig6, w_sharp_hit, w_quiet, w_stat_hit, w_change;
    logic [29:0] w_sd_x50;
    logic [32:0] w_sd_x300;
    logic [22:0] w_bd_x100, w_wd_x100, w_bdr_x100, w_wdr_x100;
    logic [22:0] w_lbr_x10, w_lwb_x30, w_rbr_x10, w_rwb_x5;

    assign w_start = (i_item.force_request == caft_pkg::FORCE_START);
    assign w_stop  = (i_item.force_request == caft_pkg::FORCE_STOP);

    // absolute differences
    assign w_sd = (i_hist.last_sharpness > i_item.sharpness)
                ? i_hist.last_sharpness - i_item.sharpness
                : i_item.sharpness - i_hist.last_sharpness;
    assign w_wd = (i_item.white_balance > i_hist.last_balance)
                ? i_item.white_balance - i_hist.last_balance
                : i_hist.last_balance - i_item.white_balance;
    assign w_bd = (i_item.brightness > i_hist.last_brightness)
                ? i_item.brightness - i_hist.last_brightness
                : i_hist.last_brightness - i_item.brightness;
    assign w_wd_ref = (i_item.white_balance > i_hist.ref_balance)
                    ? i_item.white_balance - i_hist.ref_balance
                    : i_hist.ref_balance - i_item.white_balance;
    assign w_bd_ref = (i_item.brightness > i_hist.ref_brightness)
                    ? i_item.brightness - i_hist.ref_brightness
                    : i_hist.ref_brightness - i_item.brightness;

    assign o_flags.sharp_ok = (i_item.sharpness >= caft_pkg::C_SHARP_MIN)
                           && (i_item.sharpness <= caft_pkg::C_SHARP_MAX);

    // d > last/k is the same as d*k > last for integers
    assign w_dig5    = (i_hist.last_sharpness >= caft_pkg::C_DIG5_MIN)
                    && (i_hist.last_sharpness <= caft_pkg::C_DIG5_MAX);
    assign w_dig6    = (i_hist.last_sharpness >= caft_pkg::C_DIG6_MIN)
                    && (i_hist.last_sharpness <= caft_pkg::C_DIG6_MAX);
    assign w_sd_x50  = 30'(w_sd) * 30'(caft_pkg::C_THR_DIV5);
    assign w_sd_x300 = 33'(w_sd) * 33'(caft_pkg::C_THR_DIV6);

    always_comb begin
        if (w_dig5) begin
            w_sharp_hit = (w_sd_x50 > 30'(i_hist.last_sharpness));
        end else if (w_dig6) begin
            w_sharp_hit = (w_sd_x300 > 33'(i_hist.last_sharpness));
        end else begin
            w_sharp_hit = (w_sd != 24'd0);
        end
    end

    assign w_bd_x100  = 23'(w_bd) * 23'(caft_pkg::C_PCT_SCALE);
    assign w_wd_x100  = 23'(w_wd) * 23'(caft_pkg::C_PCT_SCALE);
    assign w_lbr_x10  = 23'(i_hist.last_brightness) * 23'(caft_pkg::C_BR_PCT);
    assign w_lwb_x30  = 23'(i_hist.last_balance) * 23'(caft_pkg::C_WB_PCT_LAST);
    assign w_bdr_x100 = 23'(w_bd_ref) * 23'(caft_pkg::C_PCT_SCALE);
    assign w_wdr_x100 = 23'(w_wd_ref) * 23'(caft_pkg::C_PCT_SCALE);
    assign w_rbr_x10  = 23'(i_hist.ref_brightness) * 23'(caft_pkg::C_BR_PCT);
    assign w_rwb_x5   = 23'(i_hist.ref_balance) * 23'(caft_pkg::C_WB_PCT_REF);

    // steady light and balance veto a sharpness-only change
    assign w_quiet = (w_bd < caft_pkg::C_QUIET_LIM) && (i_item.brightness != 16'd0)
                  && (w_wd < caft_pkg::C_QUIET_LIM) && (i_item.white_balance != 16'd0)
                  && !w_stop;

    assign w_stat_hit = ((w_bd_x100 > w_lbr_x10) && (i_hist.last_brightness != 16'd0))
                     || ((w_wd_x100 > w_lwb_x30) && (i_hist.last_balance != 16'd0)
                         && (w_wd > caft_pkg::C_WB_MIN_STEP));

    assign w_change = w_stop || (w_sharp_hit ? (!w_quiet && !w_start) : w_stat_hit);

    assign o_flags.change_hit = o_flags.sharp_ok && w_change;

    assign o_flags.scene_hit = ((w_bdr_x100 > w_rbr_x10) && (i_hist.ref_brightness != 16'd0))
                            || ((w_wdr_x100 > w_rwb_x5) && (i_hist.ref_balance != 16'd0));
endmodule

/* sv/caft_ctrl.sv */
// ----------------------------------------------------------------------------
// caft_ctrl: trigger decision state
// per-frame holds, locks, capture window, arming delay and shake hold
// ----------------------------------------------------------------------------
module caft_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  caft_pkg::t_in_item  i_item,
    input  caft_pkg::t_cfg      i_cfg,
    output caft_pkg::t_out_item o_result
);
    logic        r_tracking_on, n_tracking_on;
    logic [7:0]  r_startup_cnt, n_startup_cnt;
    logic [7:0]  r_valid_cnt, n_valid_cnt;
    logic [7:0]  r_single_cnt, n_single_cnt;
    logic [7:0]  r_capture_cnt, n_capture_cnt;
    logic        r_detect_pend, n_detect_pend;
    logic        r_capture_pend, n_capture_pend;
    logic        r_motion_pend, n_motion_pend;
    logic        r_armed, n_armed;
    logic        r_change_seen, n_change_seen;
    logic        r_moving, n_moving;
    logic signed [8:0] r_delay_cnt, n_delay_cnt;
    logic signed [8:0] r_shake_cnt, n_shake_cnt;
    caft_pkg::t_hist   r_hist, n_hist;
    caft_pkg::t_flags  w_flags;
    logic              w_fire;

    caft_stats u_stats (
        .i_item  (i_item),
        .i_hist  (r_hist),
        .o_flags (w_flags)
    );

    always_comb begin : p_next
        logic              cap_now;
        logic              mot_now;
        logic              past;
        logic              f_start;
        logic              f_stop;
        logic              seen;
        logic              arm;
        logic              mov;
        logic              mot;
        logic signed [8:0] dly;
        logic signed [8:0] shk;

        f_start = (i_item.force_request == caft_pkg::FORCE_START);
        f_stop  = (i_item.force_request == caft_pkg::FORCE_STOP);
        cap_now = r_capture_pend | i_item.capture_started;
        mot_now = r_motion_pend | i_item.motion_started;
        past    = 1'b0;
        seen    = r_change_seen;
        arm     = r_armed;
        mov     = r_moving;
        mot     = mot_now;
        dly     = r_delay_cnt;
        shk     = r_shake_cnt;

        w_fire         = 1'b0;
        n_tracking_on  = r_tracking_on;
        n_startup_cnt  = r_startup_cnt;
        n_valid_cnt    = r_valid_cnt;
        n_single_cnt   = r_single_cnt;
        n_capture_cnt  = r_capture_cnt;
        n_detect_pend  = r_detect_pend;
        n_capture_pend = cap_now;
        n_motion_pend  = mot_now;
        n_armed        = r_armed;
        n_change_seen  = r_change_seen;
        n_moving       = r_moving;
        n_delay_cnt    = r_delay_cnt;
        n_shake_cnt    = r_shake_cnt;
        n_hist         = r_hist;

        if (!r_tracking_on) begin
            // startup wait, first focus once the lens is done
            past = (r_startup_cnt > i_cfg.startup_delay);
            if (r_startup_cnt != 8'hFF) begin
                n_startup_cnt = r_startup_cnt + 8'd1;
            end
            if (past && i_item.lens_settled) begin
                w_fire        = 1'b1;
                n_tracking_on = 1'b1;
                n_startup_cnt = 8'd0;
                n_valid_cnt   = i_cfg.valid_hold;
            end
        end else if (r_valid_cnt != 8'd0) begin
            n_valid_cnt   = r_valid_cnt - 8'd1;
            n_armed       = 1'b0;
            n_change_seen = 1'b0;
        end else if (i_item.single_focus_active) begin
            n_single_cnt  = i_cfg.single_hold;
            n_armed       = 1'b0;
            n_change_seen = 1'b0;
        end else if (r_single_cnt != 8'd0) begin
            n_single_cnt = r_single_cnt - 8'd1;
            if (r_single_cnt == 8'd1) begin
                n_detect_pend = 1'b1;
            end
        end else if (r_detect_pend) begin
            n_hist.ref_balance    = i_item.white_balance;
            n_hist.ref_brightness = i_item.brightness;
            if (w_flags.scene_hit && i_item.lens_settled) begin
                w_fire        = 1'b1;
                n_detect_pend = 1'b0;
                n_armed       = 1'b0;
                n_change_seen = 1'b0;
            end
        end else if (cap_now) begin
            n_hist.ref_balance    = i_item.white_balance;
            n_hist.ref_brightness = i_item.brightness;
            if (w_flags.scene_hit && i_item.lens_settled) begin
                w_fire         = 1'b1;
                n_capture_pend = 1'b0;
                n_armed        = 1'b0;
                n_change_seen  = 1'b0;
            end
            past = (r_capture_cnt > i_cfg.capture_window);
            if (r_capture_cnt != 8'hFF) begin
                n_capture_cnt = r_capture_cnt + 8'd1;
            end
            if (past) begin
                n_capture_cnt  = 8'd0;
                n_capture_pend = 1'b0;
                n_armed        = 1'b0;
                n_change_seen  = 1'b0;
            end
        end else begin
            // normal tracking: change detect, delay, stability, shake hold
            if (!r_armed) begin
                seen = w_flags.change_hit;
                if (w_flags.sharp_ok && f_stop) begin
                    mov = 1'b1;
                    mot = 1'b0;
                end
                if (seen) begin
                    dly = $signed({1'b0, i_cfg.trigger_delay});
                    arm = 1'b1;
                end
            end
            if (seen) begin
                if (mot) begin
                    seen = 1'b0;
                    shk  = 9'sd0;
                end
                if ((dly < 9'sd1) && w_flags.sharp_ok && f_start && mov) begin
                    mov = 1'b0;
                    if (i_item.lens_settled) begin
                        w_fire = 1'b1;
                        seen   = 1'b0;
                        shk    = $signed({1'b0, i_cfg.shake_hold});
                    end
                end
                if (dly > -9'sd1) begin
                    dly = dly - 9'sd1;
                end
            end
            if (shk > 9'sd0) begin
                shk = shk - 9'sd1;
            end else if (shk == 9'sd0) begin
                arm = 1'b0;
                shk = -9'sd1;
            end
            n_change_seen = seen;
            n_armed       = arm;
            n_moving      = mov;
            n_motion_pend = mot;
            n_delay_cnt   = dly;
            n_shake_cnt   = shk;
        end

        n_hist.last_sharpness  = i_item.sharpness;
        n_hist.last_balance    = i_item.white_balance;
        n_hist.last_brightness = i_item.brightness;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracking_on  <= 1'b0;
            r_startup_cnt  <= 8'd0;
            r_valid_cnt    <= 8'd0;
            r_single_cnt   <= 8'd0;
            r_capture_cnt  <= 8'd0;
            r_detect_pend  <= 1'b0;
            r_capture_pend <= 1'b0;
            r_motion_pend  <= 1'b0;
            r_armed        <= 1'b0;
            r_change_seen  <= 1'b0;
            r_moving       <= 1'b0;
            r_delay_cnt    <= 9'sd0;
            r_shake_cnt    <= 9'sd0;
            r_hist         <= '0;
        end else if (i_step) begin
            r_tracking_on  <= n_tracking_on;
            r_startup_cnt  <= n_startup_cnt;
            r_valid_cnt    <= n_valid_cnt;
            r_single_cnt   <= n_single_cnt;
            r_capture_cnt  <= n_capture_cnt;
            r_detect_pend  <= n_detect_pend;
            r_capture_pend <= n_capture_pend;
            r_motion_pend  <= n_motion_pend;
            r_armed        <= n_armed;
            r_change_seen  <= n_change_seen;
            r_moving       <= n_moving;
            r_delay_cnt    <= n_delay_cnt;
            r_shake_cnt    <= n_shake_cnt;
            r_hist         <= n_hist;
        end
    end

    assign o_result.focus_trigger  = w_fire;
    assign o_result.tracking_valid = n_tracking_on;

    // tracking never drops once the first focus has happened
    a_tracking_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tracking_on |=> r_tracking_on)
        else $error("tracking dropped");

    // delay and shake counters stay at or above their floor
    a_delay_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_delay_cnt >= -9'sd1)
        else $error("delay counter below floor");

    a_shake_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shake_cnt >= -9'sd1)
        else $error("shake counter below floor");
endmodule

/* sv/continuous_autofocus_trigger_unit.sv */
// ----------------------------------------------------------------------------
// continuous_autofocus_trigger_unit: per-frame autofocus trigger decision
// takes one beat of frame statistics and flags per frame and returns one
// beat saying whether to start an autofocus run
// ----------------------------------------------------------------------------
//  channel    dir   handshake          payload
//  i_in       in    valid / ready      t_in_item, one beat per frame
//  o_out      out   valid / ready      t_out_item, one beat per input beat
//  i_cfg_*    in    write enable only  3-bit register index, 8-bit data
//
//  one beat per cycle sustained while the output is taken; a beat waits in
//  the input register until the output register is free, then moves on
//  synchronous active-low reset clears control and decision state,
//  configuration returns to its default values
//  a stalled output holds its beat; the input register still takes a new
//  beat in the same cycle the output beat is taken
// ----------------------------------------------------------------------------
module continuous_autofocus_trigger_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    caft_if.sink        i_in,
    caft_if.source      o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    // input register stage
    logic                r_in_vld;
    caft_pkg::t_in_item  r_in;
    // output register stage
    logic                r_out_vld;
    caft_pkg::t_out_item r_out;
    // configuration registers
    caft_pkg::t_cfg      r_cfg;
    // decision result of the beat in the input register
    caft_pkg::t_out_item w_result;
    // input beat moves into the output register this cycle
    logic                w_adv;

    assign w_adv      = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_adv;

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    // decision logic and its state, stepped once per frame
    caft_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_adv),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // handshake control for both register stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    // configuration write decoder, indexes past the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= caft_pkg::C_CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                caft_pkg::CFG_STARTUP_DELAY:  r_cfg.startup_delay  <= i_cfg_data;
                caft_pkg::CFG_VALID_HOLD:     r_cfg.valid_hold     <= i_cfg_data;
                caft_pkg::CFG_SINGLE_HOLD:    r_cfg.single_hold    <= i_cfg_data;
                caft_pkg::CFG_TRIGGER_DELAY:  r_cfg.trigger_delay  <= i_cfg_data;
                caft_pkg::CFG_SHAKE_HOLD:     r_cfg.shake_hold     <= i_cfg_data;
                caft_pkg::CFG_CAPTURE_WINDOW: r_cfg.capture_window <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // a fired trigger always comes with tracking enabled
    a_fire_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (!r_out.focus_trigger || r_out.tracking_valid))
        else $error("trigger without tracking");

    // an empty output register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> i_in.ready)
        else $error("input stalled with empty output");

    // an advanced beat always lands in the output register
    a_adv_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_vld)
        else $error("advanced beat lost");
endmodule

/* tb/tb_continuous_autofocus_trigger_unit.sv */
// ----------------------------------------------------------------------------
// tb_continuous_autofocus_trigger_unit: self-checking bench for the trigger unit
// frames go in as beats on the input channel while a cycle-free software copy
// of the trigger logic predicts each output beat; every output beat is checked
// against the oldest prediction, under several idle and stall patterns
// ----------------------------------------------------------------------------
module tb_continuous_autofocus_trigger_unit;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       cfg_we;
    logic [2:0] cfg_idx;
    logic [7:0] cfg_data;

    caft_if #(.T(caft_pkg::t_in_item))  frame_ch ();
    caft_if #(.T(caft_pkg::t_out_item)) decision_ch ();

    continuous_autofocus_trigger_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (frame_ch),
        .o_out      (decision_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // 20 time unit period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // shadow of the trigger logic, updated once per accepted frame beat
    // ------------------------------------------------------------------------
    caft_pkg::t_cfg cfg_shadow  = caft_pkg::C_CFG_RESET;
    bit          trk_on         = 1'b0;
    logic [7:0]  startup_cnt    = '0;
    logic [7:0]  hold_cnt       = '0;
    logic [7:0]  single_cnt     = '0;
    logic [7:0]  capture_cnt    = '0;
    bit          detect_pend    = 1'b0;
    bit          capture_pend   = 1'b0;
    bit          motion_pend    = 1'b0;
    bit          armed_q        = 1'b0;
    bit          change_q       = 1'b0;
    bit          moving_q       = 1'b0;
    int          delay_cnt      = 0;
    int          shake_cnt      = 0;
    int unsigned prev_sharp     = 0;
    int unsigned prev_wb        = 0;
    int unsigned prev_br        = 0;
    int unsigned ref_wb         = 0;
    int unsigned ref_br         = 0;

    // predicted decisions waiting for their output beat
    caft_pkg::t_out_item pending_decisions[$];

    int errors      = 0;
    int frames_sent = 0;

    // idle pattern knobs, percent per cycle
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // long receiver hold-off, counted down by the receiver process
    int hold_off_cycles = 0;

    // scene the random frames wander around
    int sharp_base = 50000;
    int wb_base    = 4000;
    int br_base    = 3000;

    function automatic int unsigned abs_diff(int unsigned a, int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int num_digits(int unsigned v);
        int n;
        n = 0;
        while (v != 0) begin
            v = v / 10;
            n++;
        end
        return n;
    endfunction

    function automatic bit sharp_usable(int unsigned s);
        int d;
        d = num_digits(s);
        return (d >= 4) && (d <= 7);
    endfunction

    function automatic void disarm();
        armed_q  = 1'b0;
        change_q = 1'b0;
    endfunction

    // scene change against the reference statistics, reference follows the frame
    function automatic bit scene_changed(int unsigned wb, int unsigned br);
        int unsigned bd, wd;
        bit          hit;
        bd = abs_diff(br, ref_br);
        wd = abs_diff(wb, ref_wb);
        hit = (bd * 100 > ref_br * 10 && ref_br != 0) ||
              (wd * 100 > ref_wb * 5 && ref_wb != 0);
        ref_br = br;
        ref_wb = wb;
        return hit;
    endfunction

    function automatic caft_pkg::t_out_item predict_decision(caft_pkg::t_in_item f);
        int unsigned s, wb, br, sd, wd, bd, thr;
        logic [1:0]  frc;
        bit          fire, past, hit;
        int          d;
        caft_pkg::t_out_item res;
        s    = 32'(f.sharpness);
        wb   = 32'(f.white_balance);
        br   = 32'(f.brightness);
        frc  = (f.force_request == caft_pkg::FORCE_RSVD) ? caft_pkg::FORCE_NONE
                                                          : f.force_request;
        fire = 1'b0;

        // pulses latch before the frame is judged
        if (f.capture_started) capture_pend = 1'b1;
        if (f.motion_started)  motion_pend  = 1'b1;

        if (!trk_on) begin
            // startup wait, counter saturates
            past = startup_cnt > cfg_shadow.startup_delay;
            if (startup_cnt != 8'hff) startup_cnt++;
            if (past && f.lens_settled) begin
                fire        = 1'b1;
                trk_on      = 1'b1;
                startup_cnt = '0;
                hold_cnt    = cfg_shadow.valid_hold;
            end
        end else if (hold_cnt != 0) begin
            hold_cnt--;
            disarm();
        end else if (f.single_focus_active) begin
            single_cnt = cfg_shadow.single_hold;
            disarm();
        end else if (single_cnt != 0) begin
            single_cnt--;
            if (single_cnt == 0) detect_pend = 1'b1;
        end else if (detect_pend) begin
            if (scene_changed(wb, br) && f.lens_settled) begin
                fire        = 1'b1;
                detect_pend = 1'b0;
                disarm();
            end
        end else if (capture_pend) begin
            if (scene_changed(wb, br) && f.lens_settled) begin
                fire         = 1'b1;
                capture_pend = 1'b0;
                disarm();
            end
            past = capture_cnt > cfg_shadow.capture_window;
            if (capture_cnt != 8'hff) capture_cnt++;
            if (past) begin
                capture_cnt  = '0;
                capture_pend = 1'b0;
                disarm();
            end
        end else begin
            // change detector, only while not armed
            if (!armed_q) begin
                hit = 1'b0;
                if (sharp_usable(s)) begin
                    sd  = abs_diff(prev_sharp, s);
                    wd  = abs_diff(wb, prev_wb);
                    bd  = abs_diff(br, prev_br);
                    d   = num_digits(prev_sharp);
                    thr = 0;
                    if (d == 5)      thr = prev_sharp / 50;
                    else if (d == 6) thr = prev_sharp / 300;
                    hit = sd > thr;
                    if (hit) begin
                        // quiet statistics veto a sharpness change
                        if (bd < 5 && br > 0 && wd < 5 && wb > 0 &&
                            frc != caft_pkg::FORCE_STOP)
                            hit = 1'b0;
                        if (frc == caft_pkg::FORCE_START) hit = 1'b0;
                    end else if ((bd * 100 > prev_br * 10 && prev_br != 0) ||
                                 (wd * 100 > prev_wb * 30 && prev_wb != 0 && wd > 50)) begin
                        hit = 1'b1;
                    end
                    if (frc == caft_pkg::FORCE_STOP) begin
                        hit         = 1'b1;
                        moving_q    = 1'b1;
                        motion_pend = 1'b0;
                    end
                end
                change_q = hit;
                if (hit) begin
                    delay_cnt = int'(cfg_shadow.trigger_delay);
                    armed_q   = 1'b1;
                end
            end
            if (change_q) begin
                if (motion_pend) begin
                    change_q  = 1'b0;
                    shake_cnt = 0;
                end
                // stability check runs on this frame's values
                if (delay_cnt < 1 && sharp_usable(s)) begin
                    hit = 1'b0;
                    if (frc == caft_pkg::FORCE_START && moving_q) begin
                        hit      = 1'b1;
                        moving_q = 1'b0;
                    end
                    if (hit && f.lens_settled) begin
                        fire      = 1'b1;
                        change_q  = 1'b0;
                        shake_cnt = int'(cfg_shadow.shake_hold);
                    end
                end
                if (delay_cnt > -1) delay_cnt--;
            end
            // shake hold, floor at -1
            if (shake_cnt > 0) begin
                shake_cnt--;
            end else if (shake_cnt == 0) begin
                armed_q   = 1'b0;
                shake_cnt = -1;
            end
        end

        prev_sharp = s;
        prev_wb    = wb;
        prev_br    = br;
        res.focus_trigger  = fire;
        res.tracking_valid = trk_on;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic caft_pkg::t_in_item mk_frame(int unsigned s, int unsigned wb,
                                                    int unsigned br, logic [1:0] frc,
                                                    int unsigned done, int unsigned single,
                                                    int unsigned capture,
                                                    int unsigned motion);
        caft_pkg::t_in_item f;
        f.sharpness           = s[23:0];
        f.white_balance       = wb[15:0];
        f.brightness          = br[15:0];
        f.force_request       = frc;
        f.lens_settled        = done[0];
        f.single_focus_active = single[0];
        f.capture_started     = capture[0];
        f.motion_started      = motion[0];
        return f;
    endfunction

    // statistic near its base, with occasional zeros, jumps and full-range noise
    function automatic int unsigned rand_stat(inout int base);
        int sel;
        int v;
        sel = $urandom_range(99);
        if (sel < 8)  return $urandom_range(65535);
        if (sel < 12) return 0;
        if (sel < 25) begin
            base = $urandom_range(200, 60000);
            return base;
        end
        v = base + int'($urandom_range(6)) - 3;
        return (v < 0) ? 0 : v;
    endfunction

    function automatic caft_pkg::t_in_item rand_frame();
        caft_pkg::t_in_item f;
        int       sel, span, v;
        // now and then the scene moves to another decade of sharpness
        if ($urandom_range(99) < 3) begin
            case ($urandom_range(3))
                0:       sharp_base = $urandom_range(1000, 9999);
                1:       sharp_base = $urandom_range(10000, 99999);
                2:       sharp_base = $urandom_range(100000, 999999);
                default: sharp_base = $urandom_range(1000000, 9999999);
            endcase
        end
        sel = $urandom_range(99);
        if (sel < 10) begin
            f.sharpness = 24'($urandom);
        end else if (sel < 16) begin
            f.sharpness = 24'($urandom_range(999));
        end else if (sel < 19) begin
            f.sharpness = 24'($urandom_range(10000000, 16777215));
        end else begin
            span = ($urandom_range(3) == 0) ? sharp_base / 8 : sharp_base / 200;
            v    = sharp_base + int'($urandom_range(2 * span)) - span;
            f.sharpness = 24'(v);
        end
        f.white_balance = 16'(rand_stat(wb_base));
        f.brightness    = 16'(rand_stat(br_base));
        sel = $urandom_range(99);
        if (sel < 84)      f.force_request = caft_pkg::FORCE_NONE;
        else if (sel < 90) f.force_request = caft_pkg::FORCE_START;
        else if (sel < 96) f.force_request = caft_pkg::FORCE_STOP;
        else               f.force_request = caft_pkg::FORCE_RSVD;
        f.lens_settled        = $urandom_range(99) < 85;
        f.single_focus_active = $urandom_range(99) < 4;
        f.capture_started     = $urandom_range(99) < 4;
        f.motion_started      = $urandom_range(99) < 4;
        return f;
    endfunction

    // one frame beat, with random idle cycles in front of it
    task automatic send_frame(input caft_pkg::t_in_item f);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        frame_ch.valid = 1'b1;
        frame_ch.data  = f;
        do @(posedge i_clk); while (frame_ch.ready !== 1'b1);
        pending_decisions.push_back(predict_decision(f));
        frames_sent++;
        @(negedge i_clk);
        frame_ch.valid = 1'b0;
    endtask

    // registers only change once every decision beat is out
    task automatic write_reg(input caft_pkg::t_cfg_idx idx, input logic [7:0] val);
        wait (pending_decisions.size() == 0);
        repeat (3) @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
        case (idx)
            caft_pkg::CFG_STARTUP_DELAY:  cfg_shadow.startup_delay  = val;
            caft_pkg::CFG_VALID_HOLD:     cfg_shadow.valid_hold     = val;
            caft_pkg::CFG_SINGLE_HOLD:    cfg_shadow.single_hold    = val;
            caft_pkg::CFG_TRIGGER_DELAY:  cfg_shadow.trigger_delay  = val;
            caft_pkg::CFG_SHAKE_HOLD:     cfg_shadow.shake_hold     = val;
            caft_pkg::CFG_CAPTURE_WINDOW: cfg_shadow.capture_window = val;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // startup delay at its largest, startup counter saturates
    task automatic test_startup_saturation();
        write_reg(caft_pkg::CFG_STARTUP_DELAY, 8'd255);
        repeat (270) send_frame(rand_frame());
        // saturated counter is past any smaller delay, next done frame fires
        write_reg(caft_pkg::CFG_STARTUP_DELAY, 8'd0);
        repeat (10) send_frame(rand_frame());
    endtask

    // field extremes, every force code, flag pulses, short holds
    task automatic test_directed();
        write_reg(caft_pkg::CFG_VALID_HOLD, 8'd0);
        write_reg(caft_pkg::CFG_SINGLE_HOLD, 8'd1);
        write_reg(caft_pkg::CFG_TRIGGER_DELAY, 8'd0);
        write_reg(caft_pkg::CFG_SHAKE_HOLD, 8'd0);
        write_reg(caft_pkg::CFG_CAPTURE_WINDOW, 8'd0);
        send_frame(mk_frame(5000, 1000, 1000, caft_pkg::FORCE_NONE, 1, 0, 0, 0));
        // sharpness at and beyond the 4 to 7 digit bounds
        send_frame(mk_frame(0, 0, 0, caft_pkg::FORCE_STOP, 1, 0, 0, 0));
        send_frame(mk_frame(999, 65535, 65535, caft_pkg::FORCE_NONE, 1, 0, 0, 0));
        send_frame(mk_frame(1000, 65535, 65535, caft_pkg::FORCE_NONE, 1, 0, 0, 0));
        send_frame(mk_frame(9999999, 1000, 1000, caft_pkg::FORCE_NONE, 1, 0, 0, 0));
        send_frame(mk_frame(10000000, 1000, 1000, caft_pkg::FORCE_STOP, 1, 0, 0, 0));
        send_frame(mk_frame(16777215, 1000, 1000, caft_pkg::FORCE_NONE, 0, 0, 0, 0));
        // five and six digit thresholds
        send_frame(mk_frame(10000, 1000, 1000, caft_pkg::FORCE_NONE, 1, 0, 0, 0));
        send_frame(mk_frame(10199, 1000, 1000, caft_pkg::FORCE_NONE, 1, 0, 0, 0));
        send_frame(mk_frame(99999, 1002, 1001, caft_pkg::FORCE_NONE, 1, 0, 0, 0));
        send_frame(mk_frame(100000, 1000, 1000, caft_pkg::FORCE_NONE, 1, 0, 0, 0));
        send_frame(mk_frame(100334, 1000, 1000, caft_pkg::FORCE_NONE, 1, 0, 0, 0));
        // stop arms with zero delay, start on a usable frame fires
        send_frame(mk_frame(999999, 1000, 1000, caft_pkg::FORCE_STOP, 1, 0, 0, 0));
        send_frame(mk_frame(999999, 1000, 1000, caft_pkg::FORCE_START, 1, 0, 0, 0));
        // unused force code behaves as none
        send_frame(mk_frame(500000, 3000, 200, caft_pkg::FORCE_RSVD, 1, 0, 0, 0));
        // single-shot lock then hold, then a detect frame
        send_frame(mk_frame(500000, 3000, 200, caft_pkg::FORCE_NONE, 1, 1, 0, 0));
        send_frame(mk_frame(500000, 3000, 200, caft_pkg::FORCE_NONE, 1, 0, 0, 0));
        send_frame(mk_frame(500000, 9000, 900, caft_pkg::FORCE_NONE, 1, 0, 0, 0));
        // capture window of zero frames
        send_frame(mk_frame(500000, 9000, 900, caft_pkg::FORCE_NONE, 0, 0, 1, 0));
        send_frame(mk_frame(500000, 9000, 900, caft_pkg::FORCE_NONE, 0, 0, 0, 0));
        send_frame(mk_frame(500000, 1, 65535, caft_pkg::FORCE_NONE, 1, 0, 0, 0));
        // motion pulse drops a pending change
        send_frame(mk_frame(16777215, 0, 65535, caft_pkg::FORCE_STOP, 1, 0, 0, 1));
        send_frame(mk_frame(4000, 0, 0, caft_pkg::FORCE_STOP, 1, 0, 0, 1));
        send_frame(mk_frame(4000, 0, 0, caft_pkg::FORCE_START, 0, 0, 0, 0));
        send_frame(mk_frame(16777215, 65535, 65535, caft_pkg::FORCE_RSVD, 1, 1, 1, 1));
    endtask

    // single and shake holds, trigger delay and capture window at their largest, holds never expire early
    task automatic test_max_holds();
        write_reg(caft_pkg::CFG_SINGLE_HOLD, 8'd255);
        write_reg(caft_pkg::CFG_TRIGGER_DELAY, 8'd255);
        write_reg(caft_pkg::CFG_SHAKE_HOLD, 8'd255);
        write_reg(caft_pkg::CFG_CAPTURE_WINDOW, 8'd255);
        repeat (60) send_frame(rand_frame());
    endtask

    // stop, quiet frames through the trigger delay, then a start on a done lens
    task automatic send_shake_episode();
        caft_pkg::t_in_item f;
        f = rand_frame();
        f.force_request       = caft_pkg::FORCE_STOP;
        f.single_focus_active = 1'b0;
        f.capture_started     = 1'b0;
        f.motion_started      = 1'b0;
        send_frame(f);
        repeat (int'(cfg_shadow.trigger_delay) + $urandom_range(2)) begin
            f = rand_frame();
            f.force_request       = caft_pkg::FORCE_NONE;
            f.single_focus_active = 1'b0;
            f.capture_started     = 1'b0;
            f.motion_started      = 1'b0;
            send_frame(f);
        end
        f = rand_frame();
        f.sharpness           = 24'(sharp_base);
        f.force_request       = caft_pkg::FORCE_START;
        f.lens_settled        = 1'b1;
        f.single_focus_active = 1'b0;
        f.capture_started     = 1'b0;
        f.motion_started      = 1'b0;
        send_frame(f);
    endtask

    // random frames and shake episodes under one idle pattern
    task automatic test_random_phase(input int idle_pct, input int stall_pct);
        int stop_at;
        write_reg(caft_pkg::CFG_SINGLE_HOLD, 8'($urandom_range(8)));
        write_reg(caft_pkg::CFG_TRIGGER_DELAY, 8'($urandom_range(6)));
        write_reg(caft_pkg::CFG_SHAKE_HOLD, 8'($urandom_range(8)));
        write_reg(caft_pkg::CFG_CAPTURE_WINDOW, 8'($urandom_range(12)));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = frames_sent + 30;
        while (frames_sent < stop_at) begin
            if ($urandom_range(99) < 30) send_shake_episode();
            else                         send_frame(rand_frame());
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // receiver holds off while frames keep coming, input must stall
    task automatic test_backpressure();
        write_reg(caft_pkg::CFG_TRIGGER_DELAY, 8'd1);
        hold_off_cycles = 60;
        repeat (30) send_frame(rand_frame());
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stalls, or a counted hold-off when one is requested
    // ------------------------------------------------------------------------
    initial begin
        decision_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                decision_ch.ready = 1'b0;
                hold_off_cycles--;
            end else begin
                decision_ch.ready = $urandom_range(99) >= recv_stall_pct;
            end
        end
    end

    // ------------------------------------------------------------------------
    // checker: each decision beat against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        caft_pkg::t_out_item want, got;
        if (i_rst_n && decision_ch.valid === 1'b1 && decision_ch.ready === 1'b1) begin
            got = decision_ch.data;
            if (pending_decisions.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected decision beat: trigger=%b tracking=%b",
                             got.focus_trigger, got.tracking_valid);
            end else begin
                want = pending_decisions.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display({"decision mismatch: expected trigger=%b tracking=%b,",
                                  " got trigger=%b tracking=%b"},
                                 want.focus_trigger, want.tracking_valid,
                                 got.focus_trigger, got.tracking_valid);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        frame_ch.valid = 1'b0;
        frame_ch.data  = '0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_startup_saturation();
        test_directed();
        test_max_holds();
        // no idling, sender idle, receiver stalling, both
        test_random_phase(0, 0);
        test_random_phase(87, 0);
        test_random_phase(0, 87);
        test_random_phase(22, 22);
        test_backpressure();

        // drain, then wait on to catch stray beats
        wait (pending_decisions.size() == 0);
        repeat (8) @(negedge i_clk);
        if (errors == 0 && pending_decisions.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
